// ----- hdl/rk4_pkg.sv -----
// shared constants, types and step microcode for the rk4 integrator
`default_nettype none

package rk4_pkg;

    // number format and limits
    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 63;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 21;
    localparam int COUNT_W   = 6;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int NEG_W     = DATA_W + 2;
    localparam int CFG_W     = 2;

    // fixed-point constants: one half and one sixth
    localparam logic signed [DATA_W-1:0] HALF  = DATA_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [DATA_W-1:0] SIXTH =
        DATA_W'(((longint'(1) << FRAC_BITS) + 3) / 6);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration register indexes and reset values
    localparam logic [CFG_W-1:0]   CFG_STEP_SIZE  = CFG_W'(0);
    localparam logic [CFG_W-1:0]   CFG_STEP_COUNT = CFG_W'(1);
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST  = STEP_W'(13107);
    localparam logic [COUNT_W-1:0] STEP_COUNT_RST = COUNT_W'(10);

    // microcode sequence length for one integration step
    localparam int UC_LEN = 40;
    localparam int PC_W   = $clog2(UC_LEN);
    localparam logic [PC_W-1:0] UC_LAST = PC_W'(UC_LEN - 1);

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_NEG2,
        OP_MUL,
        OP_RND
    } t_op;

    // operand sources
    typedef enum logic [3:0] {
        SRC_X,
        SRC_Y,
        SRC_HH,
        SRC_XM,
        SRC_XH,
        SRC_T,
        SRC_YT,
        SRC_K1,
        SRC_K2,
        SRC_K3,
        SRC_S,
        SRC_H,
        SRC_HALF,
        SRC_SIXTH
    } t_src;

    // result destinations
    typedef enum logic [3:0] {
        DST_NONE,
        DST_X,
        DST_Y,
        DST_HH,
        DST_XM,
        DST_XH,
        DST_T,
        DST_YT,
        DST_K1,
        DST_K2,
        DST_K3,
        DST_S
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_uop;

    // command from controller to datapath
    typedef struct packed {
        logic load;
        logic capture;
        t_uop uop;
    } t_cmd;

    function automatic t_uop mk_uop(input t_op op, input t_src a, input t_src b,
                                    input t_dst d);
        t_uop u;
        u.op    = op;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        return u;
    endfunction

    localparam t_uop UOP_NOP = '{op: OP_NOP, src_a: SRC_X, src_b: SRC_X, dst: DST_NONE};

    // saturate a neg/add result to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_narrow(input logic signed [NEG_W-1:0] v);
        logic [NEG_W-DATA_W:0] top;
        top = v[NEG_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[NEG_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // saturate a shifted product to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [SH_W-1:0] v);
        logic [SH_W-DATA_W:0] top;
        top = v[SH_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[SH_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // one rk4 step: k1..k4, weighted sum over six, advance x and y
    function automatic t_uop step_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        u = UOP_NOP;
        unique case (pc)
            // half step and midpoint abscissas
            PC_W'(0):  u = mk_uop(OP_MUL,  SRC_H,  SRC_HALF,  DST_NONE);
            PC_W'(1):  u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_HH);
            PC_W'(2):  u = mk_uop(OP_ADD,  SRC_X,  SRC_HH,    DST_XM);
            PC_W'(3):  u = mk_uop(OP_ADD,  SRC_X,  SRC_H,     DST_XH);
            // k1
            PC_W'(4):  u = mk_uop(OP_NEG2, SRC_X,  SRC_X,     DST_T);
            PC_W'(5):  u = mk_uop(OP_MUL,  SRC_T,  SRC_Y,     DST_NONE);
            PC_W'(6):  u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(7):  u = mk_uop(OP_MUL,  SRC_H,  SRC_T,     DST_NONE);
            PC_W'(8):  u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_K1);
            // k2
            PC_W'(9):  u = mk_uop(OP_MUL,  SRC_K1, SRC_HALF,  DST_NONE);
            PC_W'(10): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(11): u = mk_uop(OP_ADD,  SRC_Y,  SRC_T,     DST_YT);
            PC_W'(12): u = mk_uop(OP_NEG2, SRC_XM, SRC_XM,    DST_T);
            PC_W'(13): u = mk_uop(OP_MUL,  SRC_T,  SRC_YT,    DST_NONE);
            PC_W'(14): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(15): u = mk_uop(OP_MUL,  SRC_H,  SRC_T,     DST_NONE);
            PC_W'(16): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_K2);
            // k3
            PC_W'(17): u = mk_uop(OP_MUL,  SRC_K2, SRC_HALF,  DST_NONE);
            PC_W'(18): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(19): u = mk_uop(OP_ADD,  SRC_Y,  SRC_T,     DST_YT);
            PC_W'(20): u = mk_uop(OP_NEG2, SRC_XM, SRC_XM,    DST_T);
            PC_W'(21): u = mk_uop(OP_MUL,  SRC_T,  SRC_YT,    DST_NONE);
            PC_W'(22): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(23): u = mk_uop(OP_MUL,  SRC_H,  SRC_T,     DST_NONE);
            PC_W'(24): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_K3);
            // k4, kept in t
            PC_W'(25): u = mk_uop(OP_ADD,  SRC_Y,  SRC_K3,    DST_YT);
            PC_W'(26): u = mk_uop(OP_NEG2, SRC_XH, SRC_XH,    DST_T);
            PC_W'(27): u = mk_uop(OP_MUL,  SRC_T,  SRC_YT,    DST_NONE);
            PC_W'(28): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(29): u = mk_uop(OP_MUL,  SRC_H,  SRC_T,     DST_NONE);
            PC_W'(30): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            // weighted sum k1 + 2k2 + 2k3 + k4
            PC_W'(31): u = mk_uop(OP_ADD,  SRC_K2, SRC_K2,    DST_YT);
            PC_W'(32): u = mk_uop(OP_ADD,  SRC_K1, SRC_YT,    DST_S);
            PC_W'(33): u = mk_uop(OP_ADD,  SRC_K3, SRC_K3,    DST_YT);
            PC_W'(34): u = mk_uop(OP_ADD,  SRC_S,  SRC_YT,    DST_S);
            PC_W'(35): u = mk_uop(OP_ADD,  SRC_S,  SRC_T,     DST_S);
            // advance y and x
            PC_W'(36): u = mk_uop(OP_MUL,  SRC_S,  SRC_SIXTH, DST_NONE);
            PC_W'(37): u = mk_uop(OP_RND,  SRC_X,  SRC_X,     DST_T);
            PC_W'(38): u = mk_uop(OP_ADD,  SRC_Y,  SRC_T,     DST_Y);
            PC_W'(39): u = mk_uop(OP_ADD,  SRC_X,  SRC_H,     DST_X);
            default:   u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rk4_ode_integrator.sv -----
// top level of the rk4 integrator for y' = -2xy: configuration registers and wiring
`default_nettype none

// Integrates y' = -2xy with classic fourth-order Runge-Kutta in signed Q16.16,
// with every product and sum saturating. Each accepted transaction (x0, y0)
// yields the initial point and then one point per step, step_count steps in
// all (zero gives only the initial point), the final one flagged by
// o_last_point. One step runs a microcode sequence on a single shared 32x32
// multiplier and saturating adder, and a run can be held by any output stall.
// New input is taken only when the previous run has issued its last point;
// that point may still sit in the output register. step_size and step_count
// are to be written through the configuration port only while the block is
// idle; the block itself does not enforce this.
module rk4_ode_integrator import rk4_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [DATA_W-1:0]  i_initial_x,
    input  wire logic signed [DATA_W-1:0]  i_initial_y,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed      [DATA_W-1:0]  o_point_x,
    output logic signed      [DATA_W-1:0]  o_point_y,
    output logic                           o_last_point,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic        [CFG_W-1:0]   i_cfg_index,
    input  wire logic        [STEP_W-1:0]  i_cfg_data
);

    logic [STEP_W-1:0]  r_step_size;
    logic [COUNT_W-1:0] r_step_count;
    t_cmd               w_cmd;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= STEP_SIZE_RST;
            r_step_count <= STEP_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_SIZE:  r_step_size  <= i_cfg_data;
                CFG_STEP_COUNT: r_step_count <= i_cfg_data[COUNT_W-1:0];
                default:        r_step_size  <= r_step_size;
            endcase
        end
    end

    // sequencing
    rk4_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_last_point (o_last_point),
        .i_step_count (r_step_count),
        .o_cmd        (w_cmd)
    );

    // arithmetic
    rk4_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_initial_x (i_initial_x),
        .i_initial_y (i_initial_y),
        .i_step_size (r_step_size),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y)
    );

endmodule

`default_nettype wire

// ----- hdl/rk4_datapath.sv -----
// rk4 datapath: working registers, shared multiplier, saturating adder, output register
`default_nettype none

module rk4_datapath import rk4_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_cmd                      i_cmd,
    input  wire logic signed [DATA_W-1:0]  i_initial_x,
    input  wire logic signed [DATA_W-1:0]  i_initial_y,
    input  wire logic        [STEP_W-1:0]  i_step_size,
    output logic signed      [DATA_W-1:0]  o_point_x,
    output logic signed      [DATA_W-1:0]  o_point_y
);

    // working registers
    logic signed [DATA_W-1:0] r_x, r_y, r_hh, r_xm, r_xh, r_t, r_yt;
    logic signed [DATA_W-1:0] r_k1, r_k2, r_k3, r_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_point_x, r_point_y;

    logic signed [DATA_W-1:0] w_h, w_a, w_b, w_res;
    logic signed [PROD_W-1:0] w_prod, w_prod_rnd;
    logic signed [SH_W-1:0]   w_shift;
    logic signed [NEG_W-1:0]  w_sum, w_neg;

    assign w_h = DATA_W'({1'b0, i_step_size});

    // operand a select
    always_comb begin
        case (i_cmd.uop.src_a)
            SRC_X:     w_a = r_x;
            SRC_Y:     w_a = r_y;
            SRC_HH:    w_a = r_hh;
            SRC_XM:    w_a = r_xm;
            SRC_XH:    w_a = r_xh;
            SRC_T:     w_a = r_t;
            SRC_YT:    w_a = r_yt;
            SRC_K1:    w_a = r_k1;
            SRC_K2:    w_a = r_k2;
            SRC_K3:    w_a = r_k3;
            SRC_S:     w_a = r_s;
            SRC_H:     w_a = w_h;
            SRC_HALF:  w_a = HALF;
            SRC_SIXTH: w_a = SIXTH;
            default:   w_a = r_x;
        endcase
    end

    // operand b select
    always_comb begin
        case (i_cmd.uop.src_b)
            SRC_X:     w_b = r_x;
            SRC_Y:     w_b = r_y;
            SRC_HH:    w_b = r_hh;
            SRC_XM:    w_b = r_xm;
            SRC_XH:    w_b = r_xh;
            SRC_T:     w_b = r_t;
            SRC_YT:    w_b = r_yt;
            SRC_K1:    w_b = r_k1;
            SRC_K2:    w_b = r_k2;
            SRC_K3:    w_b = r_k3;
            SRC_S:     w_b = r_s;
            SRC_H:     w_b = w_h;
            SRC_HALF:  w_b = HALF;
            SRC_SIXTH: w_b = SIXTH;
            default:   w_b = r_x;
        endcase
    end

    // shared 32x32 multiplier, product registered
    assign w_prod = w_a * w_b;

    // round to nearest with ties up, then floor shift
    assign w_prod_rnd = r_prod + PROD_W'(HALF);
    assign w_shift    = SH_W'(w_prod_rnd >>> FRAC_BITS);

    // saturating add and scaling by minus two
    assign w_sum = NEG_W'(w_a) + NEG_W'(w_b);
    assign w_neg = NEG_W'(0) - (NEG_W'(w_a) <<< 1);

    // result select
    always_comb begin
        case (i_cmd.uop.op)
            OP_ADD:  w_res = sat_narrow(w_sum);
            OP_NEG2: w_res = sat_narrow(w_neg);
            OP_RND:  w_res = sat_wide(w_shift);
            default: w_res = sat_wide(w_shift);
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop.op == OP_MUL) begin
            r_prod <= w_prod;
        end
        if (i_cmd.load) begin
            r_x <= i_initial_x;
            r_y <= i_initial_y;
        end else if (i_cmd.uop.op != OP_NOP && i_cmd.uop.op != OP_MUL) begin
            case (i_cmd.uop.dst)
                DST_X:   r_x  <= w_res;
                DST_Y:   r_y  <= w_res;
                DST_HH:  r_hh <= w_res;
                DST_XM:  r_xm <= w_res;
                DST_XH:  r_xh <= w_res;
                DST_T:   r_t  <= w_res;
                DST_YT:  r_yt <= w_res;
                DST_K1:  r_k1 <= w_res;
                DST_K2:  r_k2 <= w_res;
                DST_K3:  r_k3 <= w_res;
                DST_S:   r_s  <= w_res;
                default: r_s  <= r_s;
            endcase
        end
        // output register takes the current point
        if (i_cmd.capture) begin
            r_point_x <= r_x;
            r_point_y <= r_y;
        end
    end

    assign o_point_x = r_point_x;
    assign o_point_y = r_point_y;

endmodule

`default_nettype wire

// ----- hdl/rk4_ctrl.sv -----
// rk4 controller: run sequencing, step microcode counter and output valid
`default_nettype none

module rk4_ctrl import rk4_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_last_point,
    input  wire logic [COUNT_W-1:0] i_step_count,
    output t_cmd                    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_RUN
    } t_state;

    t_state               r_state;
    logic [PC_W-1:0]      r_pc;
    logic [COUNT_W-1:0]   r_step;
    logic [COUNT_W-1:0]   r_n;
    logic                 r_out_valid;
    logic                 r_last;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_emit;
    logic                 w_last;
    logic [COUNT_W-1:0]   w_n_clamp;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_state == ST_EMIT) && w_slot_free;
    assign w_last      = (r_step == r_n);
    assign w_n_clamp   = (i_step_count > COUNT_W'(MAX_STEPS)) ? COUNT_W'(MAX_STEPS)
                                                               : i_step_count;

    // commands to the datapath
    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.capture = w_emit;
        o_cmd.uop     = (r_state == ST_RUN) ? step_uop(r_pc) : UOP_NOP;
    end

    // state, counters and output flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_step      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            // output transaction: new point issued, or current one taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_n     <= w_n_clamp;
                        r_step  <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot_free) begin
                        r_last      <= w_last;
                        r_pc        <= '0;
                        r_state     <= w_last ? ST_IDLE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_pc == UC_LAST) begin
                        r_pc    <= '0;
                        r_step  <= r_step + COUNT_W'(1);
                        r_state <= ST_EMIT;
                    end else begin
                        r_pc <= r_pc + PC_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_last_point = r_last;

endmodule

`default_nettype wire

// ----- hdl/rk4_checker.sv -----
// port-level assertions for the rk4 integrator and their bind
`default_nettype none

module rk4_checker import rk4_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      o_in_stall,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic signed [DATA_W-1:0]  o_point_x,
    input  wire logic signed [DATA_W-1:0]  o_point_y,
    input  wire logic                      o_last_point
);

    // reset leaves no pending point and an open input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear output valid and input stall");

    // an accepted transaction starts a run
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // a run stays busy until its last point is issued
    a_run_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_point
        |=> o_in_stall || (o_out_valid && o_last_point))
        else $error("run ended without a last point");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_last_point))
        else $error("stalled output changed");

endmodule

bind rk4_ode_integrator rk4_checker u_rk4_checker (.*);

`default_nettype wire
